/* rtl/assert_macros.svh */
// assertion helpers shared by the rlkv rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked outside reset
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
// property checked on every edge
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* rtl/rlkv_pkg.sv */
package rlkv_pkg;

  // field widths
  localparam int ActW     = 3;
  localparam int SmpW     = 10;
  localparam int IdxW     = 4;
  localparam int ValW     = 16;
  localparam int NoiseW   = 9;
  localparam int LvlW     = 10;
  localparam int NcntW    = 5;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 10;
  localparam int HitW     = 3;
  // level plus margin
  localparam int SumW     = 11;

  // key hit bit positions
  localparam int HitSel = 0;
  localparam int HitDec = 1;
  localparam int HitInc = 2;

  // register reset values
  localparam logic [NoiseW-1:0] NoiseRst    = 9'd50;
  localparam logic [LvlW-1:0]   SelLvlRst   = 10'd160;
  localparam logic [LvlW-1:0]   IncLvlRst   = 10'd440;
  localparam logic [LvlW-1:0]   DecLvlRst   = 10'd260;
  localparam logic [NcntW-1:0]  NodeCntRst  = 5'd3;

  typedef enum logic [ActW-1:0] {
    ACT_SAMPLE      = 3'd0,
    ACT_ACK         = 3'd1,
    ACT_DEFINE      = 3'd2,
    ACT_RESTORE_VAL = 3'd3,
    ACT_RESTORE_POS = 3'd4,
    ACT_READ        = 3'd5
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NOISE      = 3'd0,
    CFG_SEL_LEVEL  = 3'd1,
    CFG_INC_LEVEL  = 3'd2,
    CFG_DEC_LEVEL  = 3'd3,
    CFG_NODE_COUNT = 3'd4
  } cfg_idx_e;

  // key decoder status after one word
  typedef struct packed {
    logic            check_done;
    logic [HitW-1:0] hits;
    logic            pressed;
    logic            changed;
    logic [IdxW-1:0] position;
  } ctrl_t;

endpackage

/* rtl/resistor_ladder_key_value_editor_unit.sv */
// channel  direction  handshake                  payload
// in       input      in_valid_i / in_ready_o    action, sample, node index, value, limits, step
// out      output     out_valid_o / out_ready_i  check flag, key hits, flags, position, values
// cfg      input      cfg_we_i                   cfg_index_i, cfg_data_i
//
// one word per cycle while results are taken; a word goes through the input register, then the result register
// key decoding and position update happen as the word is accepted, the node tables
// are read then and written as the word moves on to the result register
// a held result stalls the table stage, which stops input acceptance once it is full
// reset clears flags, position and burst state; node tables are not cleared

`include "assert_macros.svh"

module resistor_ladder_key_value_editor_unit #(
  parameter int NODES             = 16,
  parameter int SAMPLES_PER_CHECK = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [rlkv_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [rlkv_pkg::CfgDataW-1:0]        cfg_data_i,
  // input words
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [rlkv_pkg::ActW-1:0]            action_i,
  input  logic [rlkv_pkg::SmpW-1:0]            sample_i,
  input  logic [rlkv_pkg::IdxW-1:0]            node_index_i,
  input  logic signed [rlkv_pkg::ValW-1:0]     node_value_i,
  input  logic signed [rlkv_pkg::ValW-1:0]     limit_min_i,
  input  logic signed [rlkv_pkg::ValW-1:0]     limit_max_i,
  input  logic signed [rlkv_pkg::ValW-1:0]     step_size_i,
  // result words
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 check_done_o,
  output logic [rlkv_pkg::HitW-1:0]            key_hits_o,
  output logic                                 press_latched_o,
  output logic                                 change_ready_o,
  output logic [rlkv_pkg::IdxW-1:0]            current_position_o,
  output logic signed [rlkv_pkg::ValW-1:0]     current_value_o,
  output logic signed [rlkv_pkg::ValW-1:0]     read_result_o
);
  import rlkv_pkg::*;

  localparam int AddrW = (NODES > 1) ? $clog2(NODES) : 1;

  logic  in_fire;
  ctrl_t ctrl_next;

  // table stage registers
  logic                   s1_valid_q;
  logic                   s1_adv;
  ctrl_t                  s1_ctrl_q;
  logic [ActW-1:0]        s1_action_q;
  logic [IdxW-1:0]        s1_idx_q;
  logic signed [ValW-1:0] s1_value_q, s1_min_q, s1_max_q, s1_step_q;

  // table read data
  logic signed [ValW-1:0] val_pos, val_idx, min_pos, max_pos, step_pos;
  logic [ValW-1:0]        val_pos_raw, val_idx_raw, min_pos_raw, max_pos_raw, step_pos_raw;

  // table stage logic
  logic                   pos_ok, idx_ok, step_hit;
  logic signed [ValW-1:0] v_dec, v_inc, c_lo, c_hi;
  logic                   val_we, lim_we;
  logic [IdxW-1:0]        val_waddr;
  logic signed [ValW-1:0] val_wdata;
  logic signed [ValW-1:0] cur_val, rd_res;

  // result register
  logic                   out_valid_q;
  ctrl_t                  out_ctrl_q;
  logic signed [ValW-1:0] out_cur_q, out_rd_q;

  // handshake
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  // key decoder, burst tracking and position
  rlkv_keydec #(
    .NODES            (NODES),
    .SAMPLES_PER_CHECK(SAMPLES_PER_CHECK)
  ) u_keydec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (in_fire),
    .action_i    (action_i),
    .sample_i    (sample_i),
    .node_index_i(node_index_i),
    .ctrl_o      (ctrl_next)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ctrl_q   <= ctrl_next;
      s1_action_q <= action_i;
      s1_idx_q    <= node_index_i;
      s1_value_q  <= node_value_i;
      s1_min_q    <= limit_min_i;
      s1_max_q    <= limit_max_i;
      s1_step_q   <= step_size_i;
    end
  end

  // node tables; values are kept twice for the position and index reads
  rlkv_ram #(.Width(ValW), .Depth(NODES)) u_val_pos (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(AddrW'(val_waddr)),
    .wdata_i(val_wdata),
    .re_i   (in_fire),
    .raddr_i(AddrW'(ctrl_next.position)),
    .rdata_o(val_pos_raw)
  );

  rlkv_ram #(.Width(ValW), .Depth(NODES)) u_val_idx (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(AddrW'(val_waddr)),
    .wdata_i(val_wdata),
    .re_i   (in_fire),
    .raddr_i(AddrW'(node_index_i)),
    .rdata_o(val_idx_raw)
  );

  rlkv_ram #(.Width(ValW), .Depth(NODES)) u_min (
    .clk_i  (clk_i),
    .we_i   (lim_we),
    .waddr_i(AddrW'(s1_idx_q)),
    .wdata_i(s1_min_q),
    .re_i   (in_fire),
    .raddr_i(AddrW'(ctrl_next.position)),
    .rdata_o(min_pos_raw)
  );

  rlkv_ram #(.Width(ValW), .Depth(NODES)) u_max (
    .clk_i  (clk_i),
    .we_i   (lim_we),
    .waddr_i(AddrW'(s1_idx_q)),
    .wdata_i(s1_max_q),
    .re_i   (in_fire),
    .raddr_i(AddrW'(ctrl_next.position)),
    .rdata_o(max_pos_raw)
  );

  rlkv_ram #(.Width(ValW), .Depth(NODES)) u_step (
    .clk_i  (clk_i),
    .we_i   (lim_we),
    .waddr_i(AddrW'(s1_idx_q)),
    .wdata_i(s1_step_q),
    .re_i   (in_fire),
    .raddr_i(AddrW'(ctrl_next.position)),
    .rdata_o(step_pos_raw)
  );

  assign val_pos  = $signed(val_pos_raw);
  assign val_idx  = $signed(val_idx_raw);
  assign min_pos  = $signed(min_pos_raw);
  assign max_pos  = $signed(max_pos_raw);
  assign step_pos = $signed(step_pos_raw);

  assign pos_ok   = int'(s1_ctrl_q.position) < NODES;
  assign idx_ok   = int'(s1_idx_q) < NODES;
  assign step_hit = s1_ctrl_q.hits[HitDec] || s1_ctrl_q.hits[HitInc];

  // decrease, then increase on the decreased value
  always_comb begin
    v_dec = val_pos;
    if (s1_ctrl_q.hits[HitDec]) begin
      v_dec = (val_pos > min_pos) ? val_pos - step_pos : min_pos;
    end
    v_inc = v_dec;
    if (s1_ctrl_q.hits[HitInc]) begin
      v_inc = (v_dec < max_pos) ? v_dec + step_pos : max_pos;
    end
  end

  // limit definition clamps the stored value, raise first then lower
  assign c_lo = (val_idx < s1_min_q) ? s1_min_q : val_idx;
  assign c_hi = (c_lo > s1_max_q) ? s1_max_q : c_lo;

  // table writes as the stage hands over its result
  always_comb begin
    val_we    = 1'b0;
    val_waddr = s1_idx_q;
    val_wdata = s1_value_q;
    lim_we    = 1'b0;
    if (s1_valid_q && s1_adv) begin
      case (action_e'(s1_action_q))
        ACT_SAMPLE: begin
          if (step_hit && pos_ok) begin
            val_we    = 1'b1;
            val_waddr = s1_ctrl_q.position;
            val_wdata = v_inc;
          end
        end
        ACT_DEFINE: begin
          val_we    = idx_ok;
          lim_we    = idx_ok;
          val_wdata = c_hi;
        end
        ACT_RESTORE_VAL: begin
          val_we = idx_ok;
        end
        default: ;
      endcase
    end
  end

  // selected value after this word and read-back value
  always_comb begin
    if (!pos_ok) begin
      cur_val = '0;
    end else if (val_we && (val_waddr == s1_ctrl_q.position)) begin
      cur_val = val_wdata;
    end else begin
      cur_val = val_pos;
    end
  end

  assign rd_res = ((s1_action_q == ACT_READ) && idx_ok) ? val_idx : '0;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_ctrl_q <= s1_ctrl_q;
      out_cur_q  <= cur_val;
      out_rd_q   <= rd_res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign check_done_o       = out_ctrl_q.check_done;
  assign key_hits_o         = out_ctrl_q.hits;
  assign press_latched_o    = out_ctrl_q.pressed;
  assign change_ready_o     = out_ctrl_q.changed;
  assign current_position_o = out_ctrl_q.position;
  assign current_value_o    = out_cur_q;
  assign read_result_o      = out_rd_q;

  // a full table stage behind a held result takes no new word
  `ASSERT_RST(a_stall_blocks_input, clk_i, rst_ni,
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
  // key hits only come with a completed burst
  `ASSERT_RST(a_hits_need_check, clk_i, rst_ni,
    (s1_valid_q && (s1_ctrl_q.hits != '0)) |-> s1_ctrl_q.check_done)
  // tables only change when the stage hands over a word
  `ASSERT_RST(a_write_on_advance, clk_i, rst_ni,
    (val_we || lim_we) |-> (s1_valid_q && s1_adv))

endmodule

/* rtl/rlkv_ram.sv */
module rlkv_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, write data passes through on a collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rlkv_keydec.sv */
`include "assert_macros.svh"

module rlkv_keydec #(
  parameter int NODES             = 16,
  parameter int SAMPLES_PER_CHECK = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rlkv_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [rlkv_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                             accept_i,
  input  logic [rlkv_pkg::ActW-1:0]        action_i,
  input  logic [rlkv_pkg::SmpW-1:0]        sample_i,
  input  logic [rlkv_pkg::IdxW-1:0]        node_index_i,
  output rlkv_pkg::ctrl_t                  ctrl_o
);
  import rlkv_pkg::*;

  localparam int SpcEff = (SAMPLES_PER_CHECK < 1) ? 1 : SAMPLES_PER_CHECK;
  localparam int CntW   = (SpcEff > 1) ? $clog2(SpcEff + 1) : 1;
  localparam int NcW    = ($clog2(NODES + 1) > NcntW + 1) ? $clog2(NODES + 1) : NcntW + 1;

  logic [NoiseW-1:0] noise_q;
  logic [LvlW-1:0]   sel_lvl_q, inc_lvl_q, dec_lvl_q;
  logic [NcntW-1:0]  node_count_q;
  logic [CntW-1:0]   bcnt_q, bcnt_d;
  logic [SmpW-1:0]   bmax_q, bmax_d;
  logic              pressed_q, pressed_d;
  logic              changed_q, changed_d;
  logic [IdxW-1:0]   pos_q, pos_d;

  logic [SmpW-1:0]   r_max;
  logic [CntW-1:0]   cnt_inc;
  logic              done;
  logic [SumW-1:0]   r_sum;
  logic [LvlW-1:0]   lowest;
  logic              win_sel, win_inc, win_dec, below_low;
  logic [HitW-1:0]   hits;
  logic [NcW-1:0]    cnt_eff;
  logic [NcW-1:0]    pos_inc;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_q      <= NoiseRst;
      sel_lvl_q    <= SelLvlRst;
      inc_lvl_q    <= IncLvlRst;
      dec_lvl_q    <= DecLvlRst;
      node_count_q <= NodeCntRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_NOISE:      noise_q      <= cfg_data_i[NoiseW-1:0];
        CFG_SEL_LEVEL:  sel_lvl_q    <= cfg_data_i[LvlW-1:0];
        CFG_INC_LEVEL:  inc_lvl_q    <= cfg_data_i[LvlW-1:0];
        CFG_DEC_LEVEL:  dec_lvl_q    <= cfg_data_i[LvlW-1:0];
        CFG_NODE_COUNT: node_count_q <= cfg_data_i[NcntW-1:0];
        default: ;
      endcase
    end
  end

  // burst maximum and completion
  assign r_max   = (sample_i > bmax_q) ? sample_i : bmax_q;
  assign cnt_inc = bcnt_q + CntW'(1);
  assign done    = (action_i == ACT_SAMPLE) && (cnt_inc >= CntW'(SpcEff));
  assign r_sum   = SumW'(r_max) + SumW'(noise_q);

  // acceptance windows, compared without going negative
  assign win_sel = (SumW'(r_max) <= SumW'(sel_lvl_q) + SumW'(noise_q)) &&
                   (r_sum >= SumW'(sel_lvl_q));
  assign win_dec = (SumW'(r_max) <= SumW'(dec_lvl_q) + SumW'(noise_q)) &&
                   (r_sum >= SumW'(dec_lvl_q));
  assign win_inc = (SumW'(r_max) <= SumW'(inc_lvl_q) + SumW'(noise_q)) &&
                   (r_sum >= SumW'(inc_lvl_q));

  // release threshold below the lowest key
  always_comb begin
    lowest = sel_lvl_q;
    if (inc_lvl_q < lowest) lowest = inc_lvl_q;
    if (dec_lvl_q < lowest) lowest = dec_lvl_q;
  end
  assign below_low = r_sum < SumW'(lowest);

  always_comb begin
    hits = '0;
    if (done && !pressed_q) begin
      hits[HitSel] = win_sel;
      hits[HitDec] = win_dec;
      hits[HitInc] = win_inc;
    end
  end

  // nodes in use, clamped to between one and the table size
  always_comb begin
    if (node_count_q == '0) begin
      cnt_eff = NcW'(1);
    end else if (int'(node_count_q) > NODES) begin
      cnt_eff = NcW'(NODES);
    end else begin
      cnt_eff = NcW'(node_count_q);
    end
  end
  assign pos_inc = NcW'(pos_q) + NcW'(1);

  // next state for the word
  always_comb begin
    bcnt_d    = bcnt_q;
    bmax_d    = bmax_q;
    pressed_d = pressed_q;
    changed_d = changed_q;
    pos_d     = pos_q;
    case (action_e'(action_i))
      ACT_SAMPLE: begin
        if (done) begin
          bcnt_d = '0;
          bmax_d = '0;
          if (hits[HitSel]) begin
            pos_d = (pos_inc >= cnt_eff) ? '0 : pos_inc[IdxW-1:0];
          end
          pressed_d = pressed_q | (|hits);
          changed_d = changed_q | (below_low & pressed_d);
        end else begin
          bcnt_d = cnt_inc;
          bmax_d = r_max;
        end
      end
      ACT_ACK: begin
        pressed_d = 1'b0;
        changed_d = 1'b0;
      end
      ACT_RESTORE_POS: begin
        pos_d = node_index_i;
      end
      default: ;
    endcase
  end

  // state update on an accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q    <= '0;
      bmax_q    <= '0;
      pressed_q <= 1'b0;
      changed_q <= 1'b0;
      pos_q     <= '0;
    end else if (accept_i) begin
      bcnt_q    <= bcnt_d;
      bmax_q    <= bmax_d;
      pressed_q <= pressed_d;
      changed_q <= changed_d;
      pos_q     <= pos_d;
    end
  end

  assign ctrl_o.check_done = done;
  assign ctrl_o.hits       = hits;
  assign ctrl_o.pressed    = pressed_d;
  assign ctrl_o.changed    = changed_d;
  assign ctrl_o.position   = pos_d;

  // a release is only flagged while a press is held
  `ASSERT_RST(a_changed_needs_press, clk_i, rst_ni, changed_q |-> pressed_q)
  // burst counter never reaches the burst length
  `ASSERT_RST(a_burst_in_range, clk_i, rst_ni, int'(bcnt_q) < SpcEff)
  // a select keeps the position inside the nodes in use
  `ASSERT_RST(a_select_wraps, clk_i, rst_ni,
    (accept_i && hits[HitSel]) |=> (int'(pos_q) < int'($past(cnt_eff))))
  // acknowledge drops both flags
  `ASSERT_RST(a_ack_clears, clk_i, rst_ni,
    (accept_i && (action_i == ACT_ACK)) |=> (!pressed_q && !changed_q))

endmodule

/* tb/sv/rlkv_status_checker.sv */
// watches the word channels, predicts each result word and compares it
module rlkv_status_checker #(
  parameter int NODES             = 16,
  parameter int SAMPLES_PER_CHECK = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [rlkv_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [rlkv_pkg::CfgDataW-1:0]    cfg_data_i,
  // input channel
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [rlkv_pkg::ActW-1:0]        action_i,
  input  logic [rlkv_pkg::SmpW-1:0]        sample_i,
  input  logic [rlkv_pkg::IdxW-1:0]        node_index_i,
  input  logic signed [rlkv_pkg::ValW-1:0] node_value_i,
  input  logic signed [rlkv_pkg::ValW-1:0] limit_min_i,
  input  logic signed [rlkv_pkg::ValW-1:0] limit_max_i,
  input  logic signed [rlkv_pkg::ValW-1:0] step_size_i,
  // result channel
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic                             check_done_i,
  input  logic [rlkv_pkg::HitW-1:0]        key_hits_i,
  input  logic                             press_latched_i,
  input  logic                             change_ready_i,
  input  logic [rlkv_pkg::IdxW-1:0]        current_position_i,
  input  logic signed [rlkv_pkg::ValW-1:0] current_value_i,
  input  logic signed [rlkv_pkg::ValW-1:0] read_result_i,
  // to the top
  output int                               fail_count_o,
  output int                               pending_o
);
  import rlkv_pkg::*;

  localparam int BurstLen = (SAMPLES_PER_CHECK < 1) ? 1 : SAMPLES_PER_CHECK;

  typedef struct packed {
    ctrl_t           ctrl;
    logic [ValW-1:0] value;
    logic [ValW-1:0] readback;
  } status_t;

  // node tables and decoder state
  logic [ValW-1:0]  val_tbl  [NODES];
  logic [ValW-1:0]  min_tbl  [NODES];
  logic [ValW-1:0]  max_tbl  [NODES];
  logic [ValW-1:0]  step_tbl [NODES];
  logic [IdxW-1:0]  pos;
  logic             pressed_q;
  logic             changed_q;
  int               burst_n;
  logic [SmpW-1:0]  burst_peak;

  // register copies
  logic [NoiseW-1:0] noise_q = NoiseRst;
  logic [LvlW-1:0]   sel_q   = SelLvlRst;
  logic [LvlW-1:0]   inc_q   = IncLvlRst;
  logic [LvlW-1:0]   dec_q   = DecLvlRst;
  logic [NcntW-1:0]  count_q = NodeCntRst;

  status_t expected_status_q [$];
  int      fails;
  int      results_seen;

  function automatic bit in_window(logic [SmpW-1:0] r, logic [LvlW-1:0] lvl);
    int n;
    n = int'(noise_q);
    return (int'(r) <= int'(lvl) + n) && (int'(r) >= int'(lvl) - n);
  endfunction

  // key decoding and table editing for one word
  function automatic status_t decode_and_edit(action_e act, logic [SmpW-1:0] smp,
                                              logic [IdxW-1:0] idx,
                                              logic signed [ValW-1:0] nval,
                                              logic signed [ValW-1:0] lo,
                                              logic signed [ValW-1:0] hi,
                                              logic signed [ValW-1:0] stp);
    status_t                s;
    logic [HitW-1:0]        hits;
    logic                   done;
    logic [SmpW-1:0]        peak;
    logic signed [ValW-1:0] v;
    logic signed [ValW-1:0] lim;
    int                     span;
    int                     lowest;
    hits = '0;
    done = 1'b0;
    s.readback = '0;
    case (act)
      ACT_SAMPLE: begin
        if (smp > burst_peak) burst_peak = smp;
        burst_n++;
        if (burst_n >= BurstLen) begin
          peak = burst_peak;
          burst_n = 0;
          burst_peak = '0;
          done = 1'b1;
          span = int'(count_q);
          if (span < 1) span = 1;
          if (span > NODES) span = NODES;
          if (!pressed_q) begin
            hits[HitSel] = in_window(peak, sel_q);
            hits[HitDec] = in_window(peak, dec_q);
            hits[HitInc] = in_window(peak, inc_q);
          end
          // select first, the steps then act on the new position
          if (hits[HitSel]) begin
            pos = (int'(pos) + 1 >= span) ? '0 : pos + 1'b1;
            pressed_q = 1'b1;
          end
          if (hits[HitDec]) begin
            v = val_tbl[pos];
            lim = min_tbl[pos];
            val_tbl[pos] = (v > lim) ? v - step_tbl[pos] : lim;
            pressed_q = 1'b1;
          end
          if (hits[HitInc]) begin
            v = val_tbl[pos];
            lim = max_tbl[pos];
            val_tbl[pos] = (v < lim) ? v + step_tbl[pos] : lim;
            pressed_q = 1'b1;
          end
          // release seen below the lowest window
          lowest = int'(sel_q);
          if (int'(inc_q) < lowest) lowest = int'(inc_q);
          if (int'(dec_q) < lowest) lowest = int'(dec_q);
          if (int'(peak) < lowest - int'(noise_q) && pressed_q) changed_q = 1'b1;
        end
      end
      ACT_ACK: begin
        pressed_q = 1'b0;
        changed_q = 1'b0;
      end
      ACT_DEFINE: begin
        v = val_tbl[idx];
        min_tbl[idx] = lo;
        max_tbl[idx] = hi;
        step_tbl[idx] = stp;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        val_tbl[idx] = v;
      end
      ACT_RESTORE_VAL: val_tbl[idx] = nval;
      ACT_RESTORE_POS: pos = idx;
      ACT_READ: s.readback = val_tbl[idx];
      default: ;
    endcase
    s.ctrl.check_done = done;
    s.ctrl.hits = hits;
    s.ctrl.pressed = pressed_q;
    s.ctrl.changed = changed_q;
    s.ctrl.position = pos;
    s.value = val_tbl[pos];
    return s;
  endfunction

  task automatic check_field(string name, logic [ValW-1:0] want, logic [ValW-1:0] got);
    if (want !== got) begin
      fails++;
      if (fails <= 10)
        $display("result word %0d, %s: expected %h, got %h", results_seen, name, want, got);
    end
  endtask

  // compare accepted result words, predict accepted input words
  always @(posedge clk_i or negedge rst_ni) begin : watch
    status_t want;
    if (!rst_ni) begin
      pos = '0;
      pressed_q = 1'b0;
      changed_q = 1'b0;
      burst_n = 0;
      burst_peak = '0;
      noise_q = NoiseRst;
      sel_q = SelLvlRst;
      inc_q = IncLvlRst;
      dec_q = DecLvlRst;
      count_q = NodeCntRst;
      expected_status_q.delete();
      fails = 0;
      results_seen = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_seen++;
        if (expected_status_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("result word %0d arrived with none expected", results_seen);
        end else begin
          want = expected_status_q.pop_front();
          check_field("check_done", ValW'(want.ctrl.check_done), ValW'(check_done_i));
          check_field("key_hits", ValW'(want.ctrl.hits), ValW'(key_hits_i));
          check_field("press_latched", ValW'(want.ctrl.pressed), ValW'(press_latched_i));
          check_field("change_ready", ValW'(want.ctrl.changed), ValW'(change_ready_i));
          check_field("current_position", ValW'(want.ctrl.position),
                      ValW'(current_position_i));
          check_field("current_value", want.value, current_value_i);
          check_field("read_result", want.readback, read_result_i);
        end
      end
      if (in_valid_i && in_ready_i)
        expected_status_q.push_back(decode_and_edit(action_e'(action_i), sample_i,
                                                    node_index_i, node_value_i, limit_min_i,
                                                    limit_max_i, step_size_i));
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_NOISE:      noise_q = cfg_data_i[NoiseW-1:0];
          CFG_SEL_LEVEL:  sel_q = cfg_data_i[LvlW-1:0];
          CFG_INC_LEVEL:  inc_q = cfg_data_i[LvlW-1:0];
          CFG_DEC_LEVEL:  dec_q = cfg_data_i[LvlW-1:0];
          CFG_NODE_COUNT: count_q = cfg_data_i[NcntW-1:0];
          default: ;
        endcase
      end
      fail_count_o <= fails;
      pending_o <= expected_status_q.size();
    end
  end

endmodule

/* tb/sv/tb_resistor_ladder_key_value_editor_unit.sv */
module tb_resistor_ladder_key_value_editor_unit;
  import rlkv_pkg::*;

  localparam int Nodes    = 16;
  localparam int BurstLen = 10;

  typedef struct packed {
    action_e         act;
    logic [SmpW-1:0] smp;
    logic [IdxW-1:0] idx;
    logic [ValW-1:0] val;
    logic [ValW-1:0] lo;
    logic [ValW-1:0] hi;
    logic [ValW-1:0] stp;
  } word_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]     cfg_index_i = '0;
  logic [CfgDataW-1:0]    cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [ActW-1:0]        action_i = '0;
  logic [SmpW-1:0]        sample_i = '0;
  logic [IdxW-1:0]        node_index_i = '0;
  logic signed [ValW-1:0] node_value_i = '0;
  logic signed [ValW-1:0] limit_min_i = '0;
  logic signed [ValW-1:0] limit_max_i = '0;
  logic signed [ValW-1:0] step_size_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic                   check_done_o;
  logic [HitW-1:0]        key_hits_o;
  logic                   press_latched_o;
  logic                   change_ready_o;
  logic [IdxW-1:0]        current_position_o;
  logic signed [ValW-1:0] current_value_o;
  logic signed [ValW-1:0] read_result_o;

  int fail_count;
  int pending;

  // stimulus state
  int idle_odds = 20;
  bit calm = 1'b0;
  int hold_requests = 0;
  int words_sent = 0;
  int smp_cnt = 0;
  int settings_used = 1;
  int noise_cfg = int'(NoiseRst);
  int sel_cfg = int'(SelLvlRst);
  int inc_cfg = int'(IncLvlRst);
  int dec_cfg = int'(DecLvlRst);

  always #2 clk_i = ~clk_i;

  resistor_ladder_key_value_editor_unit #(
    .NODES(Nodes),
    .SAMPLES_PER_CHECK(BurstLen)
  ) uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .action_i, .sample_i, .node_index_i, .node_value_i,
    .limit_min_i, .limit_max_i, .step_size_i,
    .out_valid_o, .out_ready_i, .check_done_o, .key_hits_o, .press_latched_o,
    .change_ready_o, .current_position_o, .current_value_o, .read_result_o
  );

  rlkv_status_checker #(
    .NODES(Nodes),
    .SAMPLES_PER_CHECK(BurstLen)
  ) status_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .action_i, .sample_i, .node_index_i,
    .node_value_i, .limit_min_i, .limit_max_i, .step_size_i,
    .out_valid_i(out_valid_o), .out_ready_i, .check_done_i(check_done_o),
    .key_hits_i(key_hits_o), .press_latched_i(press_latched_o),
    .change_ready_i(change_ready_o), .current_position_i(current_position_o),
    .current_value_i(current_value_o), .read_result_i(read_result_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // every field random, the caller fixes what matters
  function automatic word_t any_word(action_e a);
    word_t w;
    w.act = a;
    w.smp = SmpW'($urandom_range(0, 1023));
    w.idx = IdxW'($urandom_range(0, Nodes - 1));
    w.val = ValW'($urandom_range(0, 65535));
    w.lo  = ValW'($urandom_range(0, 65535));
    w.hi  = ValW'($urandom_range(0, 65535));
    w.stp = ValW'($urandom_range(0, 65535));
    return w;
  endfunction

  function automatic logic [ValW-1:0] pick_val();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return ValW'($urandom_range(0, 65535));
    endcase
  endfunction

  // limits mostly ordered with small steps, sometimes anything at all
  function automatic word_t define_word(int node, bit wide);
    word_t w;
    int    lo;
    w = any_word(ACT_DEFINE);
    w.idx = IdxW'(node);
    if (!wide) begin
      lo = 0 - int'($urandom_range(0, 3000));
      w.lo = 16'(lo);
      w.hi = 16'(lo + int'($urandom_range(0, 6000)));
      w.stp = ValW'($urandom_range(1, 400));
    end
    return w;
  endfunction

  function automatic int level_of(int k);
    case (k)
      0: return sel_cfg;
      1: return dec_cfg;
      default: return inc_cfg;
    endcase
  endfunction

  // burst peak on or around a window edge
  function automatic int peak_near(int lvl);
    int p;
    case ($urandom_range(0, 5))
      0: p = lvl;
      1: p = lvl + noise_cfg;
      2: p = lvl - noise_cfg;
      3: p = lvl + noise_cfg + 1;
      4: p = lvl - noise_cfg - 1;
      default: p = lvl - noise_cfg + int'($urandom_range(0, 2 * noise_cfg));
    endcase
    if (p < 0) p = 0;
    if (p > 1023) p = 1023;
    return p;
  endfunction

  // peak below the lowest window, if there is room for one
  function automatic int release_peak();
    int floor_lvl;
    floor_lvl = sel_cfg;
    if (inc_cfg < floor_lvl) floor_lvl = inc_cfg;
    if (dec_cfg < floor_lvl) floor_lvl = dec_cfg;
    floor_lvl = floor_lvl - noise_cfg;
    if (floor_lvl <= 0) return 0;
    if ($urandom_range(0, 1)) return floor_lvl - 1;
    return int'($urandom_range(0, floor_lvl - 1));
  endfunction

  // offer one word and wait for it to be taken
  task automatic put(word_t w);
    if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    action_i <= w.act;
    sample_i <= w.smp;
    node_index_i <= w.idx;
    node_value_i <= w.val;
    limit_min_i <= w.lo;
    limit_max_i <= w.hi;
    step_size_i <= w.stp;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
    if (w.act == ACT_SAMPLE) smp_cnt++;
  endtask

  // finish the current burst with the given peak
  task automatic burst(int peak);
    int    n;
    int    hot;
    word_t w;
    n = BurstLen - smp_cnt % BurstLen;
    hot = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      w = any_word(ACT_SAMPLE);
      w.smp = (i == hot) ? SmpW'(peak) : SmpW'($urandom_range(0, peak));
      put(w);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_reg(cfg_idx_e r, int d);
    cfg_we_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= CfgDataW'(d);
    @(posedge clk_i);
  endtask

  task automatic apply_setting(int ph);
    int c;
    case (ph)
      1: begin
        noise_cfg = 20; sel_cfg = 100; inc_cfg = 700; dec_cfg = 400; c = 5;
      end
      2: begin
        noise_cfg = 0; sel_cfg = 0; inc_cfg = 1023; dec_cfg = 512; c = 16;
      end
      3: begin
        noise_cfg = 511; sel_cfg = 1023; inc_cfg = 0; dec_cfg = 341; c = 1;
      end
      4: begin
        noise_cfg = $urandom_range(0, 80);
        sel_cfg = $urandom_range(0, 1023);
        inc_cfg = $urandom_range(0, 1023);
        dec_cfg = $urandom_range(0, 1023);
        c = $urandom_range(1, 16);
      end
      default: begin
        noise_cfg = 35; sel_cfg = 682; inc_cfg = 900; dec_cfg = 250; c = 10;
      end
    endcase
    set_reg(CFG_NOISE, noise_cfg);
    set_reg(CFG_SEL_LEVEL, sel_cfg);
    set_reg(CFG_INC_LEVEL, inc_cfg);
    set_reg(CFG_DEC_LEVEL, dec_cfg);
    set_reg(CFG_NODE_COUNT, c);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // one random episode: most often press, release and acknowledge
  task automatic random_episode();
    word_t w;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      burst(peak_near(level_of($urandom_range(0, 2))));
      if ($urandom_range(0, 3) == 0) burst(peak_near(level_of($urandom_range(0, 2))));
      if ($urandom_range(0, 9) < 7) burst(release_peak());
      if ($urandom_range(0, 3) == 0) put(any_word(ACT_READ));
      if ($urandom_range(0, 9) < 9) put(any_word(ACT_ACK));
    end else if (r < 60) begin
      case ($urandom_range(0, 3))
        0: begin
          w = any_word(ACT_RESTORE_VAL);
          w.val = pick_val();
          put(w);
        end
        1: put(define_word($urandom_range(0, Nodes - 1), $urandom_range(0, 3) == 0));
        2: put(any_word(ACT_RESTORE_POS));
        default: put(any_word(ACT_READ));
      endcase
    end else if (r < 72) begin
      repeat ($urandom_range(1, 5)) put(any_word(ACT_SAMPLE));
    end else if (r < 80) begin
      put(any_word(ACT_ACK));
    end else begin
      burst($urandom_range(0, 1023));
    end
  endtask

  // result side: random stalls and requested long hold-offs
  initial begin : result_sink
    int holds_done;
    holds_done = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (holds_done < hold_requests) begin
        holds_done++;
        out_ready_i <= 1'b0;
        repeat (150) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    word_t w;
    int    target;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // load every node before anything reads the tables
    for (int i = 0; i < Nodes; i++) begin
      w = any_word(ACT_RESTORE_VAL);
      w.idx = IdxW'(i);
      put(w);
    end
    for (int i = 0; i < Nodes; i++) put(define_word(i, 1'b0));

    // directed: wrap from a position beyond the node count on the upper select edge
    w = any_word(ACT_RESTORE_POS);
    w.idx = IdxW'(Nodes - 1);
    put(w);
    burst(sel_cfg + noise_cfg);
    put(any_word(ACT_ACK));
    // extreme values and inverted limits
    w = any_word(ACT_RESTORE_VAL);
    w.idx = 4'd1;
    w.val = 16'h8000;
    put(w);
    w.idx = 4'd2;
    w.val = 16'h7fff;
    put(w);
    w = any_word(ACT_DEFINE);
    w.idx = 4'd3;
    w.lo = 16'sd100;
    w.hi = -16'sd100;
    w.stp = 16'd1;
    put(w);
    w = any_word(ACT_READ);
    w.idx = IdxW'(Nodes - 1);
    put(w);
    w.idx = 4'd0;
    put(w);

    // long receiver hold-off while words keep coming
    hold_requests <= hold_requests + 1;
    idle_odds = 0;
    repeat (3) burst($urandom_range(0, 1023));

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        apply_setting(ph);
      end
      idle_odds = (ph == 5) ? 0 : $urandom_range(5, 30);
      calm = (ph == 5);
      target = words_sent + 250;
      while (words_sent < target) random_episode();
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("%0d words sent under %0d register settings, %0d burst checks",
             words_sent, settings_used, smp_cnt / BurstLen);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // overall limit
  initial begin : watchdog
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
